>>> rtl/uart_ring_buffer_controller_defines.svh
// assertion macros for the uart ring buffer controller
`ifndef UART_RING_BUFFER_CONTROLLER_DEFINES_SVH
`define UART_RING_BUFFER_CONTROLLER_DEFINES_SVH

// plain property checked on every rising clock edge outside reset
`define URB_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent implies consequent in the next clock cycle
`define URB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/urb_pkg.sv
// shared types, constants and helper functions for the uart ring buffer controller
`timescale 1ns / 1ps
package urb_pkg;

  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;
  localparam int RX_PTR_W = $clog2(RX_DEPTH);
  localparam int TX_PTR_W = $clog2(TX_DEPTH);
  localparam int CNT_W    = 6;
  localparam int BYTE_W   = 8;

  localparam logic [CNT_W-1:0] COUNT_MAX   = 6'd63;
  localparam logic [CNT_W-1:0] RX_FULL_CNT =
    (RX_DEPTH - 1 > 63) ? 6'd63 : CNT_W'(RX_DEPTH - 1);

  typedef enum logic [1:0] {
    CMD_SEND    = 2'd0,
    CMD_READ    = 2'd1,
    CMD_LINE_RX = 2'd2,
    CMD_TX_DONE = 2'd3
  } cmd_e;

  typedef struct packed {
    logic              read_valid;
    logic [BYTE_W-1:0] read_byte;
    logic              send_accepted;
    logic              tx_start;
    logic [BYTE_W-1:0] tx_byte;
    logic              rx_dropped;
    logic [CNT_W-1:0]  rx_count;
    logic [CNT_W-1:0]  tx_free;
  } result_t;

  typedef struct packed {
    logic                rx_we;
    logic [RX_PTR_W-1:0] rx_waddr;
    logic [BYTE_W-1:0]   rx_wdata;
    logic [RX_PTR_W-1:0] rx_raddr;
    logic                tx_we;
    logic [TX_PTR_W-1:0] tx_waddr;
    logic [BYTE_W-1:0]   tx_wdata;
    logic [TX_PTR_W-1:0] tx_raddr;
  } mem_req_t;

  function automatic logic [RX_PTR_W-1:0] rx_inc(logic [RX_PTR_W-1:0] p);
    return (p == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [TX_PTR_W-1:0] tx_inc(logic [TX_PTR_W-1:0] p);
    return (p == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // occupancy of a ring, value always below its depth
  function automatic logic [RX_PTR_W:0] rx_used(logic [RX_PTR_W-1:0] wr,
                                                 logic [RX_PTR_W-1:0] rd);
    if (wr >= rd) begin
      return {1'b0, wr} - {1'b0, rd};
    end
    return {1'b0, wr} + (RX_PTR_W+1)'(RX_DEPTH) - {1'b0, rd};
  endfunction

  function automatic logic [TX_PTR_W:0] tx_used(logic [TX_PTR_W-1:0] wr,
                                                 logic [TX_PTR_W-1:0] rd);
    if (wr >= rd) begin
      return {1'b0, wr} - {1'b0, rd};
    end
    return {1'b0, wr} + (TX_PTR_W+1)'(TX_DEPTH) - {1'b0, rd};
  endfunction

  function automatic logic [CNT_W-1:0] rx_sat(logic [RX_PTR_W:0] v);
    if (32'(v) > 32'(COUNT_MAX)) begin
      return COUNT_MAX;
    end
    return CNT_W'(v);
  endfunction

  function automatic logic [CNT_W-1:0] tx_sat(logic [TX_PTR_W:0] v);
    if (32'(v) > 32'(COUNT_MAX)) begin
      return COUNT_MAX;
    end
    return CNT_W'(v);
  endfunction

endpackage

>>> rtl/urb_ram.sv
// generic single write port ram with registered, write-first read
`timescale 1ns / 1ps
module urb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // a read of the entry written at the same edge returns the new data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/urb_step.sv
// ring pointer state and per-event update logic for both rings
`timescale 1ns / 1ps
module urb_step import urb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_en_i,
  input  cmd_e              cmd_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic [BYTE_W-1:0] rx_rdata_i,
  input  logic [BYTE_W-1:0] tx_rdata_i,
  output result_t           result_o,
  output mem_req_t          mem_o
);

  logic [RX_PTR_W-1:0] rx_wr_q, rx_wr_d, rx_rd_q, rx_rd_d;
  logic [TX_PTR_W-1:0] tx_wr_q, tx_wr_d, tx_rd_q, tx_rd_d;
  logic                tx_active_q, tx_active_d;
  logic                rx_empty, rx_full, tx_empty, tx_full;
  logic                rx_we, tx_we;
  logic [RX_PTR_W-1:0] rx_wr_nxt;
  logic [TX_PTR_W-1:0] tx_wr_nxt;
  logic [TX_PTR_W:0]   tx_used_d;
  result_t             res;

  assign rx_wr_nxt = rx_inc(rx_wr_q);
  assign tx_wr_nxt = tx_inc(tx_wr_q);
  assign rx_empty  = (rx_rd_q == rx_wr_q);
  assign rx_full   = (rx_wr_nxt == rx_rd_q);
  assign tx_empty  = (tx_rd_q == tx_wr_q);
  assign tx_full   = (tx_wr_nxt == tx_rd_q);

  always_comb begin
    rx_wr_d     = rx_wr_q;
    rx_rd_d     = rx_rd_q;
    tx_wr_d     = tx_wr_q;
    tx_rd_d     = tx_rd_q;
    tx_active_d = tx_active_q;
    rx_we       = 1'b0;
    tx_we       = 1'b0;
    res         = '0;
    case (cmd_i)
      CMD_SEND: begin
        if (!tx_full) begin
          tx_we             = 1'b1;
          tx_wr_d           = tx_wr_nxt;
          res.send_accepted = 1'b1;
          if (!tx_active_q) begin
            // ring was empty: the byte just pushed goes straight out
            res.tx_start = 1'b1;
            res.tx_byte  = tx_empty ? data_byte_i : tx_rdata_i;
            tx_rd_d      = tx_inc(tx_rd_q);
            tx_active_d  = 1'b1;
          end
        end
      end
      CMD_READ: begin
        if (!rx_empty) begin
          res.read_valid = 1'b1;
          res.read_byte  = rx_rdata_i;
          rx_rd_d        = rx_inc(rx_rd_q);
        end
      end
      CMD_LINE_RX: begin
        if (!rx_full) begin
          rx_we   = 1'b1;
          rx_wr_d = rx_wr_nxt;
        end else begin
          res.rx_dropped = 1'b1;
        end
      end
      CMD_TX_DONE: begin
        tx_active_d = 1'b0;
        if (!tx_empty) begin
          res.tx_start = 1'b1;
          res.tx_byte  = tx_rdata_i;
          tx_rd_d      = tx_inc(tx_rd_q);
          tx_active_d  = 1'b1;
        end
      end
      default: begin
        res = '0;
      end
    endcase
    tx_used_d    = tx_used(tx_wr_d, tx_rd_d);
    res.rx_count = rx_sat(rx_used(rx_wr_d, rx_rd_d));
    res.tx_free  = tx_sat((TX_PTR_W+1)'(TX_DEPTH - 1) - tx_used_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wr_q     <= '0;
      rx_rd_q     <= '0;
      tx_wr_q     <= '0;
      tx_rd_q     <= '0;
      tx_active_q <= 1'b0;
    end else if (step_en_i) begin
      rx_wr_q     <= rx_wr_d;
      rx_rd_q     <= rx_rd_d;
      tx_wr_q     <= tx_wr_d;
      tx_rd_q     <= tx_rd_d;
      tx_active_q <= tx_active_d;
    end
  end

  assign result_o = res;

  // read addresses follow the pointers as they stand after this edge
  always_comb begin
    mem_o.rx_we    = rx_we && step_en_i;
    mem_o.rx_waddr = rx_wr_q;
    mem_o.rx_wdata = data_byte_i;
    mem_o.rx_raddr = step_en_i ? rx_rd_d : rx_rd_q;
    mem_o.tx_we    = tx_we && step_en_i;
    mem_o.tx_waddr = tx_wr_q;
    mem_o.tx_wdata = data_byte_i;
    mem_o.tx_raddr = step_en_i ? tx_rd_d : tx_rd_q;
  end

endmodule

>>> rtl/uart_ring_buffer_controller.sv
// top level: input register, ring update, result register and the two ring rams
//
// uart ring buffer controller. a host and a uart line share two ring fifos, rx and
// tx, each keeping one slot empty, so a ring of depth n holds n-1 bytes. every input
// beat (cmd, data_byte) yields exactly one result beat. an accepted beat waits in the
// input register, where the ring update works on it, and its result is then
// registered in the result register, which makes the result beat valid.
// sustained rate is one beat per cycle while the result side does not stall: the
// pointer update is combinational ahead of the pointer registers and each
// ring ram is read at the pointer value that holds after the beat ahead, so the
// entry is ready when the beat reaches the update stage. back pressure from the
// result side holds the input register and the ring state until the result is taken.
// ram contents are undefined after reset; no clearing pass is needed since only
// written entries are ever popped. rx_count and tx_free saturate at 63.
`timescale 1ns / 1ps
`include "uart_ring_buffer_controller_defines.svh"
module uart_ring_buffer_controller import urb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              read_valid_o,
  output logic [BYTE_W-1:0] read_byte_o,
  output logic              send_accepted_o,
  output logic              tx_start_o,
  output logic [BYTE_W-1:0] tx_byte_o,
  output logic              rx_dropped_o,
  output logic [CNT_W-1:0]  rx_count_o,
  output logic [CNT_W-1:0]  tx_free_o
);

  // input register
  logic              in_valid_q, in_valid_d;
  cmd_e              cmd_q;
  logic [BYTE_W-1:0] data_q;

  // result register
  logic              out_valid_q, out_valid_d;
  result_t           result_q;

  logic              advance;   // result register can take a new beat
  logic              accept;    // input beat taken this edge
  logic              step_en;   // buffered beat is processed this edge
  result_t           step_res;
  mem_req_t          mem_req;
  logic [BYTE_W-1:0] rx_rdata, tx_rdata;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign step_en    = in_valid_q && advance;

  // input register valid: loads on accept, drains when processed
  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (step_en) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(cmd_i);
      data_q <= data_byte_i;
    end
  end

  // pointer state and event decode
  urb_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step_en),
    .cmd_i       (cmd_q),
    .data_byte_i (data_q),
    .rx_rdata_i  (rx_rdata),
    .tx_rdata_i  (tx_rdata),
    .result_o    (step_res),
    .mem_o       (mem_req)
  );

  // ring storage, read on accept so the entry lines up with the buffered beat
  urb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.rx_we),
    .waddr_i (mem_req.rx_waddr),
    .wdata_i (mem_req.rx_wdata),
    .re_i    (accept),
    .raddr_i (mem_req.rx_raddr),
    .rdata_o (rx_rdata)
  );

  urb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.tx_we),
    .waddr_i (mem_req.tx_waddr),
    .wdata_i (mem_req.tx_wdata),
    .re_i    (accept),
    .raddr_i (mem_req.tx_raddr),
    .rdata_o (tx_rdata)
  );

  // result register valid: set by a processed beat, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (step_en) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      result_q <= step_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_valid_o    = result_q.read_valid;
  assign read_byte_o     = result_q.read_byte;
  assign send_accepted_o = result_q.send_accepted;
  assign tx_start_o      = result_q.tx_start;
  assign tx_byte_o       = result_q.tx_byte;
  assign rx_dropped_o    = result_q.rx_dropped;
  assign rx_count_o      = result_q.rx_count;
  assign tx_free_o       = result_q.tx_free;

  // input side stalls only behind a blocked result
  `URB_ASSERT(a_stall_cause, !in_stall_o || (out_valid_o && out_stall_i), "stall without cause")
  // a processed beat always shows a result next cycle
  `URB_ASSERT_NEXT(a_step_result, step_en, out_valid_o, "processed beat lost")
  // a dropped line byte means the rx ring reports full
  `URB_ASSERT(a_drop_full, !(out_valid_o && rx_dropped_o) || (rx_count_o == RX_FULL_CNT), "drop while rx ring not full")

endmodule
